>>> hdl/rcia_pkg.sv
// Shared constants, result type and bit search helper of the channel identifier allocator.
package rcia_pkg;

  localparam int unsigned FIRST_ID_DEF = 64;
  localparam int unsigned ID_COUNT_DEF = 1024;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned BIT_W  = 5;

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP  = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_UNBOUND = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] granted_id;
    logic [7:0]  owner_out;
  } result_t;

  function automatic logic [BIT_W-1:0] lowest_index(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] iso;
    logic [BIT_W-1:0]  idx;
    iso = v & (~v + WORD_W'(1));
    idx = '0;
    for (int k = 0; k < WORD_W; k++) begin
      if (iso[k]) begin
        idx = idx | BIT_W'(k);
      end
    end
    return idx;
  endfunction

endpackage

>>> hdl/rcia_ram.sv
// Single-port-write, single-port-read synchronous memory with a registered read.
module rcia_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/rcia_ctrl.sv
// Command sequencer: clearing pass, bitmap word scan, release read-modify-write and lookup read.
module rcia_ctrl #(
  parameter int unsigned FIRST_ID = rcia_pkg::FIRST_ID_DEF,
  parameter int unsigned ID_COUNT = rcia_pkg::ID_COUNT_DEF,
  parameter int unsigned WORDS    = (ID_COUNT + rcia_pkg::WORD_W - 1) / rcia_pkg::WORD_W,
  parameter int unsigned WA_W     = (WORDS > 1) ? $clog2(WORDS) : 1,
  parameter int unsigned OFF_W    = $clog2(ID_COUNT)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    cmd,
  input  logic [15:0]                   channel_id,
  input  logic [7:0]                    owner_tag,
  output logic                          res_valid,
  input  logic                          res_ready,
  output rcia_pkg::result_t             res,
  output logic                          bm_wr_en,
  output logic [WA_W-1:0]               bm_wr_addr,
  output logic [rcia_pkg::WORD_W-1:0]   bm_wr_data,
  output logic                          bm_rd_en,
  output logic [WA_W-1:0]               bm_rd_addr,
  input  logic [rcia_pkg::WORD_W-1:0]   bm_rd_data,
  output logic                          ow_wr_en,
  output logic [OFF_W-1:0]              ow_wr_addr,
  output logic [7:0]                    ow_wr_data,
  output logic                          ow_rd_en,
  output logic [OFF_W-1:0]              ow_rd_addr,
  input  logic [7:0]                    ow_rd_data
);

  import rcia_pkg::*;

  localparam int unsigned OFFX_W = WA_W + BIT_W;
  localparam int unsigned CNT_W  = $clog2(WORDS + 1);
  localparam logic [WA_W-1:0]  LAST_WORD  = WA_W'(WORDS - 1);
  localparam logic [OFF_W-1:0] LAST_OFF   = OFF_W'(ID_COUNT - 1);
  localparam logic [CNT_W-1:0] LAST_VISIT = CNT_W'(WORDS);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LRD, S_LCHK, S_ARD, S_ASCAN, S_RES
  } state_t;

  state_t           state;
  logic [WA_W-1:0]  clr_addr;
  logic [1:0]       cmd_q;
  logic [15:0]      id_q;
  logic [7:0]       tag_q;
  logic [OFF_W-1:0] off_q;
  logic [OFF_W-1:0] next_offset;
  logic [WA_W-1:0]  chk_word;
  logic [CNT_W-1:0] visit;

  logic [17:0]        diff;
  logic               in_win;
  logic [OFFX_W-1:0]  start_x;
  logic [BIT_W-1:0]   start_bit;
  logic [WA_W-1:0]    start_word;
  logic [OFFX_W-1:0]  lk_x;
  logic [BIT_W-1:0]   lk_bit;
  logic [WA_W-1:0]    lk_word;
  logic               lk_used;
  logic [WORD_W-1:0]  win_mask;
  logic [WORD_W-1:0]  hi_mask;
  logic [WORD_W-1:0]  scan_mask;
  logic [WORD_W-1:0]  free;
  logic [WORD_W-1:0]  free_low;
  logic               found;
  logic [BIT_W-1:0]   fbit;
  logic [OFFX_W-1:0]  found_x;
  logic [OFF_W-1:0]   found_off;
  logic [WA_W-1:0]    next_word;
  logic               first_visit;
  logic               last_visit;

  assign diff   = 18'(channel_id) - 18'(FIRST_ID);
  assign in_win = !diff[17] && (diff[16:0] < 17'(ID_COUNT));

  assign start_x    = OFFX_W'(next_offset);
  assign start_bit  = start_x[BIT_W-1:0];
  assign start_word = start_x[OFFX_W-1:BIT_W];

  assign lk_x    = OFFX_W'(off_q);
  assign lk_bit  = lk_x[BIT_W-1:0];
  assign lk_word = lk_x[OFFX_W-1:BIT_W];
  assign lk_used = bm_rd_data[lk_bit];

  assign first_visit = (visit == '0);
  assign last_visit  = (visit == LAST_VISIT);

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      win_mask[b] = ((OFFX_W + 1)'({chk_word, BIT_W'(b)}) < (OFFX_W + 1)'(ID_COUNT));
      hi_mask[b]  = (BIT_W'(b) >= start_bit);
    end
  end

  assign scan_mask = win_mask & (first_visit ? hi_mask : '1) & (last_visit ? ~hi_mask : '1);
  assign free      = ~bm_rd_data & scan_mask;
  assign free_low  = free & (~free + WORD_W'(1));
  assign found     = |free;
  assign fbit      = lowest_index(free);
  assign found_x   = {chk_word, fbit};
  assign found_off = found_x[OFF_W-1:0];
  assign next_word = (chk_word == LAST_WORD) ? '0 : chk_word + 1'b1;

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_RES);

  always_comb begin
    bm_wr_en   = 1'b0;
    bm_wr_addr = chk_word;
    bm_wr_data = bm_rd_data | free_low;
    bm_rd_en   = 1'b0;
    bm_rd_addr = next_word;
    ow_wr_en   = 1'b0;
    ow_wr_addr = found_off;
    ow_wr_data = tag_q;
    ow_rd_en   = 1'b0;
    ow_rd_addr = off_q;
    case (state)
      S_CLEAR: begin
        bm_wr_en   = 1'b1;
        bm_wr_addr = clr_addr;
        bm_wr_data = '0;
      end
      S_LRD: begin
        bm_rd_en   = 1'b1;
        bm_rd_addr = lk_word;
        ow_rd_en   = 1'b1;
      end
      S_LCHK: begin
        bm_wr_en   = (cmd_q == CMD_RELEASE) && lk_used;
        bm_wr_addr = lk_word;
        bm_wr_data = bm_rd_data & ~(WORD_W'(1) << lk_bit);
      end
      S_ARD: begin
        bm_rd_en   = 1'b1;
        bm_rd_addr = start_word;
      end
      S_ASCAN: begin
        bm_rd_en = 1'b1;
        bm_wr_en = found;
        ow_wr_en = found;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      next_offset <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (clr_addr == LAST_WORD) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_q <= cmd;
            id_q  <= channel_id;
            tag_q <= owner_tag;
            off_q <= diff[OFF_W-1:0];
            if (cmd == CMD_ALLOC) begin
              state <= S_ARD;
            end else if (cmd == CMD_UNUSED || !in_win) begin
              res   <= '{status: ST_RANGE, granted_id: '0, owner_out: '0};
              state <= S_RES;
            end else begin
              state <= S_LRD;
            end
          end
        end
        S_LRD: begin
          state <= S_LCHK;
        end
        S_LCHK: begin
          if (lk_used) begin
            res <= '{status: ST_OK, granted_id: id_q, owner_out: ow_rd_data};
          end else begin
            res <= '{status: ST_UNBOUND, granted_id: '0, owner_out: '0};
          end
          state <= S_RES;
        end
        S_ARD: begin
          chk_word <= start_word;
          visit    <= '0;
          state    <= S_ASCAN;
        end
        S_ASCAN: begin
          if (found) begin
            res <= '{status: ST_OK,
                     granted_id: 16'(18'(FIRST_ID) + 18'(found_off)),
                     owner_out: tag_q};
            next_offset <= (found_off == LAST_OFF) ? '0 : found_off + 1'b1;
            state       <= S_RES;
          end else if (last_visit) begin
            res   <= '{status: ST_FULL, granted_id: '0, owner_out: '0};
            state <= S_RES;
          end else begin
            chk_word <= next_word;
            visit    <= visit + 1'b1;
          end
        end
        S_RES: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/rotating_channel_id_allocator.sv
// Top level of the rotating channel identifier allocator: memories, sequencer, output register.
//
// Hands out identifiers FIRST_ID .. FIRST_ID+ID_COUNT-1 round robin from a next pointer,
// and releases or looks up the owner of bound identifiers. The used bits live in a
// memory of 32-bit words, the owner tags in a memory of one byte per identifier. After
// reset a clearing pass zeroes the used bitmap, one word a cycle, before the first
// command word is taken. A release or lookup reads the bitmap word and owner tag, then
// checks the used bit (clearing it on a release) before its result; a rejected command
// goes straight to its result. An allocate reads the bitmap one word a cycle from the
// pointer with wraparound, which the single read port of the bitmap memory allows. The
// result waits in an output register, so the next command word is taken while the
// previous result is still unread.
module rotating_channel_id_allocator #(
  parameter int unsigned FIRST_ID = rcia_pkg::FIRST_ID_DEF,
  parameter int unsigned ID_COUNT = rcia_pkg::ID_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [15:0] channel_id,
  input  logic [7:0]  owner_tag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] granted_id,
  output logic [7:0]  owner_out
);

  import rcia_pkg::*;

  localparam int unsigned WORDS = (ID_COUNT + WORD_W - 1) / WORD_W;
  localparam int unsigned WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned OFF_W = $clog2(ID_COUNT);

  result_t           res;
  logic              res_valid;
  logic              res_ready;
  logic              bm_wr_en;
  logic [WA_W-1:0]   bm_wr_addr;
  logic [WORD_W-1:0] bm_wr_data;
  logic              bm_rd_en;
  logic [WA_W-1:0]   bm_rd_addr;
  logic [WORD_W-1:0] bm_rd_data;
  logic              ow_wr_en;
  logic [OFF_W-1:0]  ow_wr_addr;
  logic [7:0]        ow_wr_data;
  logic              ow_rd_en;
  logic [OFF_W-1:0]  ow_rd_addr;
  logic [7:0]        ow_rd_data;

  rcia_ctrl #(
    .FIRST_ID (FIRST_ID),
    .ID_COUNT (ID_COUNT),
    .WORDS    (WORDS),
    .WA_W     (WA_W),
    .OFF_W    (OFF_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .channel_id (channel_id),
    .owner_tag  (owner_tag),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .bm_wr_en   (bm_wr_en),
    .bm_wr_addr (bm_wr_addr),
    .bm_wr_data (bm_wr_data),
    .bm_rd_en   (bm_rd_en),
    .bm_rd_addr (bm_rd_addr),
    .bm_rd_data (bm_rd_data),
    .ow_wr_en   (ow_wr_en),
    .ow_wr_addr (ow_wr_addr),
    .ow_wr_data (ow_wr_data),
    .ow_rd_en   (ow_rd_en),
    .ow_rd_addr (ow_rd_addr),
    .ow_rd_data (ow_rd_data)
  );

  rcia_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS),
    .AW    (WA_W)
  ) u_used_ram (
    .clk     (clk),
    .wr_en   (bm_wr_en),
    .wr_addr (bm_wr_addr),
    .wr_data (bm_wr_data),
    .rd_en   (bm_rd_en),
    .rd_addr (bm_rd_addr),
    .rd_data (bm_rd_data)
  );

  rcia_ram #(
    .WIDTH (8),
    .DEPTH (ID_COUNT),
    .AW    (OFF_W)
  ) u_owner_ram (
    .clk     (clk),
    .wr_en   (ow_wr_en),
    .wr_addr (ow_wr_addr),
    .wr_data (ow_wr_data),
    .rd_en   (ow_rd_en),
    .rd_addr (ow_rd_addr),
    .rd_data (ow_rd_data)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status     <= res.status;
      granted_id <= res.granted_id;
      owner_out  <= res.owner_out;
    end
  end

endmodule

>>> sim/tb_rotating_channel_id_allocator.sv
// Self-checking testbench for the rotating channel identifier allocator.
`timescale 1ns / 100ps

module tb_rotating_channel_id_allocator;
  import rcia_pkg::*;

  localparam int unsigned WIN_BASE    = FIRST_ID_DEF;
  localparam int unsigned WIN_SIZE    = ID_COUNT_DEF;
  localparam int unsigned WIN_END     = WIN_BASE + WIN_SIZE;
  localparam int          PHASE_WORDS = 280;
  localparam int          STALL_LIMIT = 3000;
  localparam int          DRAIN_WAIT  = 64;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] id;
    logic [7:0]  tag;
    logic        pinned;
    result_t     res;
  } probe_t;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd        = CMD_ALLOC;
  logic [15:0] channel_id = 16'd0;
  logic [7:0]  owner_tag  = 8'd0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [1:0]  status;
  logic [15:0] granted_id;
  logic [7:0]  owner_out;

  bit          id_taken [WIN_SIZE];
  logic [7:0]  id_owner [WIN_SIZE];
  int unsigned rover;
  int unsigned bound_q [$];
  result_t     answers_due [$];
  probe_t      probes [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int errors         = 0;
  int quiet_cycles   = 0;

  rotating_channel_id_allocator #(
    .FIRST_ID (WIN_BASE),
    .ID_COUNT (WIN_SIZE)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .channel_id (channel_id),
    .owner_tag  (owner_tag),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .granted_id (granted_id),
    .owner_out  (owner_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t serve_word(input logic [1:0] op, input logic [15:0] id,
                                         input logic [7:0] tag);
    result_t     r;
    int unsigned off;
    bit          found;
    int          hit;
    r     = '0;
    found = 1'b0;
    hit   = -1;
    if (op == CMD_ALLOC) begin
      r.status = ST_FULL;
      for (int unsigned i = 0; i < WIN_SIZE && !found; i++) begin
        off = (rover + i) % WIN_SIZE;
        if (!id_taken[off]) begin
          found         = 1'b1;
          id_taken[off] = 1'b1;
          id_owner[off] = tag;
          rover         = (off + 1) % WIN_SIZE;
          r.status      = ST_OK;
          r.granted_id  = 16'(WIN_BASE + off);
          r.owner_out   = tag;
          bound_q.push_back(off);
        end
      end
    end else if (op == CMD_UNUSED || id < WIN_BASE || id >= WIN_END) begin
      r.status = ST_RANGE;
    end else begin
      off = id - WIN_BASE;
      if (!id_taken[off]) begin
        r.status = ST_UNBOUND;
      end else begin
        r.status     = ST_OK;
        r.granted_id = id;
        r.owner_out  = id_owner[off];
        if (op == CMD_RELEASE) begin
          id_taken[off] = 1'b0;
          foreach (bound_q[k]) begin
            if (bound_q[k] == off) hit = k;
          end
          if (hit >= 0) bound_q.delete(hit);
        end
      end
    end
    return r;
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [15:0] id, input logic [7:0] tag,
                           input logic pinned, input result_t pinned_res);
    result_t r;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    cmd        <= op;
    channel_id <= id;
    owner_tag  <= tag;
    do @(posedge clk); while (in_ready !== 1'b1);
    r = serve_word(op, id, tag);
    answers_due.push_back(pinned ? pinned_res : r);
  endtask

  task automatic send_random(input int alloc_pct);
    int          pick;
    logic [1:0]  op;
    logic [15:0] id;
    pick = $urandom_range(99);
    if (pick < alloc_pct) begin
      op = CMD_ALLOC;
    end else begin
      pick = $urandom_range(9);
      op = (pick < 5) ? CMD_RELEASE : (pick < 9) ? CMD_LOOKUP : CMD_UNUSED;
    end
    pick = $urandom_range(99);
    if (pick < 65 && bound_q.size() > 0) begin
      id = 16'(WIN_BASE + bound_q[$urandom_range(bound_q.size() - 1)]);
    end else if (pick < 80) begin
      id = 16'(WIN_BASE + $urandom_range(WIN_SIZE - 1));
    end else if (pick < 93) begin
      id = 16'($urandom_range(16'hFFFF));
    end else begin
      case ($urandom_range(3))
        0: id = 16'(WIN_BASE - 1);
        1: id = 16'(WIN_BASE);
        2: id = 16'(WIN_END - 1);
        default: id = 16'(WIN_END);
      endcase
    end
    send_word(op, id, 8'($urandom_range(255)), 1'b0, '0);
  endtask

  task automatic add_probe(input logic [1:0] op, input logic [15:0] id, input logic [7:0] tag,
                           input logic pinned, input logic [1:0] st, input logic [15:0] gid,
                           input logic [7:0] own);
    probe_t p;
    p.op             = op;
    p.id             = id;
    p.tag            = tag;
    p.pinned         = pinned;
    p.res.status     = st;
    p.res.granted_id = gid;
    p.res.owner_out  = own;
    probes.push_back(p);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (answers_due.size() == 0) begin
        $display("%0t: result with none pending: status %0d id %0d owner %0d",
                 $time, status, granted_id, owner_out);
        errors++;
      end else begin
        want = answers_due.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          errors++;
        end
        if (granted_id !== want.granted_id) begin
          $display("%0t: granted_id expected %0d actual %0d", $time, want.granted_id,
                   granted_id);
          errors++;
        end
        if (owner_out !== want.owner_out) begin
          $display("%0t: owner_out expected %0d actual %0d", $time, want.owner_out, owner_out);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int alloc_pct;
    int fill_n;
    rover = 0;
    foreach (id_taken[k]) id_taken[k] = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    add_probe(CMD_LOOKUP,  16'(WIN_BASE),     8'h00, 1'b1, ST_UNBOUND, 16'd0, 8'd0);
    add_probe(CMD_RELEASE, 16'(WIN_END - 1),  8'h00, 1'b1, ST_UNBOUND, 16'd0, 8'd0);
    add_probe(CMD_ALLOC,   16'd0,             8'hFF, 1'b1, ST_OK, 16'(WIN_BASE), 8'hFF);
    add_probe(CMD_ALLOC,   16'hFFFF,          8'h00, 1'b1, ST_OK, 16'(WIN_BASE + 1), 8'h00);
    add_probe(CMD_LOOKUP,  16'(WIN_BASE),     8'h00, 1'b1, ST_OK, 16'(WIN_BASE), 8'hFF);
    add_probe(CMD_LOOKUP,  16'(WIN_BASE + 1), 8'hFF, 1'b1, ST_OK, 16'(WIN_BASE + 1), 8'h00);
    add_probe(CMD_LOOKUP,  16'(WIN_BASE - 1), 8'h00, 1'b1, ST_RANGE, 16'd0, 8'd0);
    add_probe(CMD_RELEASE, 16'(WIN_END),      8'h00, 1'b1, ST_RANGE, 16'd0, 8'd0);
    add_probe(CMD_LOOKUP,  16'd0,             8'h00, 1'b1, ST_RANGE, 16'd0, 8'd0);
    add_probe(CMD_RELEASE, 16'hFFFF,          8'hFF, 1'b1, ST_RANGE, 16'd0, 8'd0);
    add_probe(CMD_UNUSED,  16'(WIN_BASE),     8'hFF, 1'b1, ST_RANGE, 16'd0, 8'd0);
    add_probe(CMD_UNUSED,  16'd0,             8'h00, 1'b1, ST_RANGE, 16'd0, 8'd0);
    add_probe(CMD_LOOKUP,  16'hAAAA,          8'h55, 1'b1, ST_RANGE, 16'd0, 8'd0);
    add_probe(CMD_LOOKUP,  16'h5555,          8'hAA, 1'b1, ST_RANGE, 16'd0, 8'd0);
    add_probe(CMD_RELEASE, 16'(WIN_BASE),     8'h00, 1'b1, ST_OK, 16'(WIN_BASE), 8'hFF);
    add_probe(CMD_RELEASE, 16'(WIN_BASE),     8'h00, 1'b1, ST_UNBOUND, 16'd0, 8'd0);
    add_probe(CMD_LOOKUP,  16'(WIN_BASE),     8'h00, 1'b1, ST_UNBOUND, 16'd0, 8'd0);
    add_probe(CMD_ALLOC,   16'd0,             8'h5A, 1'b0, ST_OK, 16'd0, 8'd0);
    add_probe(CMD_ALLOC,   16'hFFFF,          8'hA5, 1'b0, ST_OK, 16'd0, 8'd0);
    add_probe(CMD_RELEASE, 16'(WIN_BASE + 1), 8'h00, 1'b1, ST_OK, 16'(WIN_BASE + 1), 8'h00);
    add_probe(CMD_ALLOC,   16'h1234,          8'h3C, 1'b0, ST_OK, 16'd0, 8'd0);
    add_probe(CMD_LOOKUP,  16'(WIN_END - 1),  8'h00, 1'b0, ST_OK, 16'd0, 8'd0);

    foreach (probes[k]) begin
      send_word(probes[k].op, probes[k].id, probes[k].tag, probes[k].pinned, probes[k].res);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          alloc_pct      = 60;
        end
        1: begin
          send_idle_pct  = 83;
          recv_stall_pct = 0;
          alloc_pct      = 85;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 83;
          alloc_pct      = 35;
        end
        default: begin
          send_idle_pct  = 32;
          recv_stall_pct = 32;
          alloc_pct      = 60;
        end
      endcase
      if (ph == 2) begin
        // fill the window, then push past full
        fill_n = WIN_SIZE - bound_q.size() + 6;
        repeat (fill_n) begin
          send_word(CMD_ALLOC, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)),
                    1'b0, '0);
        end
      end
      repeat (PHASE_WORDS) send_random(alloc_pct);
    end

    in_valid       <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
